/* hdl/fqs_pkg.sv */
// fqs_pkg: item types and action codes for the FIFO queue with search.
// No dependencies; used by fifo_queue_with_search.
package fqs_pkg;

    localparam int KEY_W = 32;
    localparam int POS_W = 4;
    localparam int CNT_W = 5;

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic                    ok;
        logic signed [KEY_W-1:0] popped_key;
        logic                    found;
        logic [POS_W-1:0]        found_position;
        logic [CNT_W-1:0]        entry_count;
        logic signed [KEY_W-1:0] head_key;
        logic signed [KEY_W-1:0] tail_key;
    } out_item_t;

endpackage

/* hdl/fqs_ram.sv */
// fqs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/fifo_queue_with_search.sv */
// fifo_queue_with_search: ring-buffer queue of 32-bit keys with push, pop,
// sequential search and clear. Depends on fqs_pkg and fqs_ram.
//
// Usage:
//   s_valid/s_ready/s_item carries one action item (push, pop, search or
//   clear plus a key). m_valid/m_ready/m_item returns exactly one result
//   item per action: ok flag, popped key, search hit and position, entry
//   count and the head and tail keys after the action.
// Timing: push, clear, refused push/pop, pop of the only key and search of
//   an empty queue write their result at the accepting edge (into the
//   output register, or the holding register on a stall).
//   A pop leaving keys behind first waits on the RAM read of the new head.
//   A search reads the head from RAM, then compares k entries, k = hit
//   position + 1 (or the count on a miss), so up to DEPTH; the single RAM
//   read port and the one key comparator step through the ring one entry per cycle.
//   s_ready is high only while the sequencer is idle, so one action is in
//   work at a time.
// Stall: the result sits in the output register while m_ready is low; the
//   next item is still taken, and its result waits in a holding register
//   until the output register frees, with s_ready low meanwhile.
// Reset (aresetn low, synchronous): queue empty, indices zero, no result
//   pending. The key RAM is not cleared; only written entries are read.
module fifo_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fqs_pkg::in_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output fqs_pkg::out_item_t m_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_POPRD = 4'b0010,   // waiting on RAM read of the new head
        ST_SCAN  = 4'b0100,   // one entry compared per cycle
        ST_EMIT  = 4'b1000    // result held until output register frees
    } state_t;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    state_t                     state_reg, state_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              tail_reg, tail_next;
    logic [CW-1:0]              occ_reg, occ_next;
    logic [fqs_pkg::KEY_W-1:0]  head_key_reg, head_key_next;
    logic [fqs_pkg::KEY_W-1:0]  tail_key_reg, tail_key_next;
    logic [fqs_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [fqs_pkg::KEY_W-1:0]  pop_key_reg, pop_key_next;
    logic [AW-1:0]              slot_reg, slot_next;
    logic [AW-1:0]              scan_n_reg, scan_n_next;
    fqs_pkg::out_item_t         res_reg, res_next;
    fqs_pkg::out_item_t         m_item_reg, m_item_next;
    logic                       m_valid_reg, m_valid_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [fqs_pkg::KEY_W-1:0]  ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [fqs_pkg::KEY_W-1:0]  ram_rdata;

    fqs_pkg::out_item_t         res_val;
    logic                       res_done;
    logic                       out_free;

    fqs_ram #(
        .WIDTH (fqs_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        head_key_next = head_key_reg;
        tail_key_next = tail_key_reg;
        key_next      = key_reg;
        pop_key_next  = pop_key_reg;
        slot_next     = slot_reg;
        scan_n_next   = scan_n_reg;
        res_next      = res_reg;
        m_item_next   = m_item_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata = s_item.key;
        ram_raddr = head_reg;

        res_val    = '0;
        res_val.ok = 1'b1;
        res_done   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_item.action)
                        fqs_pkg::ACT_PUSH: begin
                            res_done = 1'b1;
                            if (occ_reg == FULL_CNT) begin
                                res_val.ok = 1'b0;
                            end else begin
                                ram_we        = 1'b1;
                                tail_next     = ring_next(tail_reg);
                                occ_next      = occ_reg + 1'b1;
                                tail_key_next = s_item.key;
                                if (occ_reg == '0) begin
                                    head_key_next = s_item.key;
                                end
                            end
                        end
                        fqs_pkg::ACT_POP: begin
                            if (occ_reg == '0) begin
                                res_val.ok = 1'b0;
                                res_done   = 1'b1;
                            end else begin
                                head_next = ring_next(head_reg);
                                occ_next  = occ_reg - 1'b1;
                                if (occ_reg == CW'(1)) begin
                                    res_val.popped_key = head_key_reg;
                                    res_done           = 1'b1;
                                end else begin
                                    // fetch the key that becomes the new head
                                    ram_raddr    = ring_next(head_reg);
                                    pop_key_next = head_key_reg;
                                    state_next   = ST_POPRD;
                                end
                            end
                        end
                        fqs_pkg::ACT_SEARCH: begin
                            if (occ_reg == '0) begin
                                res_done = 1'b1;
                            end else begin
                                ram_raddr   = head_reg;
                                key_next    = s_item.key;
                                slot_next   = head_reg;
                                scan_n_next = '0;
                                state_next  = ST_SCAN;
                            end
                        end
                        fqs_pkg::ACT_CLEAR: begin
                            head_next = '0;
                            tail_next = '0;
                            occ_next  = '0;
                            res_done  = 1'b1;
                        end
                        default: begin
                            res_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_POPRD: begin
                head_key_next      = ram_rdata;
                res_val.popped_key = pop_key_reg;
                res_done           = 1'b1;
            end
            ST_SCAN: begin
                // ram_rdata holds the entry at slot_reg, position scan_n_reg
                if (ram_rdata == key_reg) begin
                    res_val.found          = 1'b1;
                    res_val.found_position = fqs_pkg::POS_W'(scan_n_reg);
                    res_done               = 1'b1;
                end else if (CW'(scan_n_reg) + 1'b1 == occ_reg) begin
                    res_done = 1'b1;
                end else begin
                    ram_raddr   = ring_next(slot_reg);
                    slot_next   = ring_next(slot_reg);
                    scan_n_next = scan_n_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // occupancy and end keys reflect the state after the action
        res_val.entry_count = fqs_pkg::CNT_W'(occ_next);
        if (occ_next != '0) begin
            res_val.head_key = head_key_next;
            res_val.tail_key = tail_key_next;
        end

        if (res_done) begin
            if (out_free) begin
                m_item_next  = res_val;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end else begin
                res_next   = res_val;
                state_next = ST_EMIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_key_reg <= head_key_next;
        tail_key_reg <= tail_key_next;
        key_reg      <= key_next;
        pop_key_reg  <= pop_key_next;
        slot_reg     <= slot_next;
        scan_n_reg   <= scan_n_next;
        res_reg      <= res_next;
        m_item_reg   <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* tb/fqs_tb_pkg.sv */
`timescale 1ns / 100ps
// fqs_tb_pkg: shadow copy of the key queue plus the result checker used by
// tb_fifo_queue_with_search. Depends on fqs_pkg.
package fqs_tb_pkg;
    import fqs_pkg::*;

    localparam int QDEPTH      = 16;

    class key_queue_shadow;
        logic signed [KEY_W-1:0] ring_keys [QDEPTH];
        int head_slot;
        int tail_slot;
        int held;
        out_item_t pending_status [$];
        int mismatches;
        int checked;
        int refused_pushes;
        int refused_pops;
        int search_hits;
        int last_slot_hits;
        int clears;

        function new();
            head_slot      = 0;
            tail_slot      = 0;
            held           = 0;
            mismatches     = 0;
            checked        = 0;
            refused_pushes = 0;
            refused_pops   = 0;
            search_hits    = 0;
            last_slot_hits = 0;
            clears         = 0;
        endfunction

        // Applies one action to the shadow ring and returns its status item.
        function out_item_t apply_action(in_item_t it);
            out_item_t st;
            int slot;
            int n;
            st    = '0;
            st.ok = 1'b1;
            case (it.action)
                ACT_PUSH: begin
                    if (held >= QDEPTH) begin
                        st.ok = 1'b0;
                        refused_pushes++;
                    end else begin
                        ring_keys[tail_slot] = it.key;
                        tail_slot = (tail_slot + 1) % QDEPTH;
                        held++;
                    end
                end
                ACT_POP: begin
                    if (held == 0) begin
                        st.ok = 1'b0;
                        refused_pops++;
                    end else begin
                        st.popped_key = ring_keys[head_slot];
                        head_slot = (head_slot + 1) % QDEPTH;
                        held--;
                    end
                end
                ACT_SEARCH: begin
                    slot = head_slot;
                    for (n = 0; n < held; n++) begin
                        if (!st.found && ring_keys[slot] == it.key) begin
                            st.found          = 1'b1;
                            st.found_position = POS_W'(n);
                        end
                        slot = (slot + 1) % QDEPTH;
                    end
                    if (st.found) begin
                        search_hits++;
                        if (st.found_position == POS_W'(QDEPTH - 1))
                            last_slot_hits++;
                    end
                end
                default: begin
                    head_slot = 0;
                    tail_slot = 0;
                    held      = 0;
                    clears++;
                end
            endcase
            st.entry_count = CNT_W'(held);
            if (held != 0) begin
                st.head_key = ring_keys[head_slot];
                st.tail_key = ring_keys[(tail_slot + QDEPTH - 1) % QDEPTH];
            end
            return st;
        endfunction

        function void note_action(in_item_t it);
            pending_status.push_back(apply_action(it));
        endfunction

        function int outstanding();
            return pending_status.size();
        endfunction

        function int held_keys();
            return held;
        endfunction

        // Key at a position counted from the head; only held positions are asked.
        function logic signed [KEY_W-1:0] key_at(int pos);
            return ring_keys[(head_slot + pos) % QDEPTH];
        endfunction

        function void compare_field(string fname, logic [KEY_W-1:0] want,
                                    logic [KEY_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                         $time, fname, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (pending_status.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_status.pop_front();
            compare_field("ok",             KEY_W'(want.ok),             KEY_W'(got.ok));
            compare_field("popped_key",     want.popped_key,             got.popped_key);
            compare_field("found",          KEY_W'(want.found),          KEY_W'(got.found));
            compare_field("found_position", KEY_W'(want.found_position),
                          KEY_W'(got.found_position));
            compare_field("entry_count",    KEY_W'(want.entry_count),
                          KEY_W'(got.entry_count));
            compare_field("head_key",       want.head_key,               got.head_key);
            compare_field("tail_key",       want.tail_key,               got.tail_key);
        endfunction
    endclass

endpackage

/* tb/tb_fifo_queue_with_search.sv */
`timescale 1ns / 100ps
// tb_fifo_queue_with_search: random and directed test of the key queue with
// search. Depends on fqs_pkg, fqs_tb_pkg and fifo_queue_with_search.
module tb_fifo_queue_with_search;
    import fqs_pkg::*;
    import fqs_tb_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int          PHASE_ITEMS  = 460;
    localparam int          LONG_HOLD    = 400;   // receiver hold-off, in cycles
    localparam int          DRAIN_CYCLES = 40;    // outlasts the slowest search
    localparam int unsigned CYCLE_LIMIT  = 500000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_item_t  s_item  = '0;
    logic      s_ready;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Idle rates in percent, set per phase by the stimulus process.
    int src_idle_pct = 0;
    int dst_idle_pct = 0;

    // Long output stall request: the stimulus bumps stall_asked, the
    // receiver notices the change and counts the hold-off itself.
    int unsigned stall_asked = 0;
    int unsigned stall_taken = 0;
    int unsigned hold_left   = 0;

    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;

    key_queue_shadow shadow;

    fifo_queue_with_search #(
        .DEPTH (QDEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #CLK_HALF aclk = ~aclk;

    // Run limit: generous multiple of the slowest legal run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Run timed out after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: check every accepted result, then pick m_ready for the
    // next cycle (random idling, or a long hold-off when asked).
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            shadow.check_result(m_item);
        if (stall_asked != stall_taken) begin
            stall_taken = stall_asked;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Offer one item; may idle first. Returns at the edge that accepts it.
    // s_valid stays high after acceptance so the next item follows back to back.
    task automatic send_item(logic [1:0] act, logic signed [KEY_W-1:0] key);
        in_item_t it;
        it.action = act;
        it.key    = key;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        shadow.note_action(it);
        items_sent++;
    endtask

    // Sender pause: drop valid and wait until every result has come back.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (shadow.outstanding() != 0);
    endtask

    // Keys: a small pool (duplicates, extremes) so searches hit and first
    // match matters; otherwise full random or single-bit patterns.
    function automatic logic signed [KEY_W-1:0] draw_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            case ($urandom_range(7))
                0:       return 32'sh0000_0000;
                1:       return 32'sh0000_0001;
                2:       return 32'sh0000_0002;
                3:       return 32'sh0000_002a;
                4:       return -32'sd1;
                5:       return 32'sh8000_0000;
                6:       return 32'sh7fff_ffff;
                default: return 32'sh0000_0003;
            endcase
        end else if (pick < 90) begin
            return $urandom;
        end else if (pick < 95) begin
            return KEY_W'(1) << $urandom_range(KEY_W - 1);
        end else begin
            return ~(KEY_W'(1) << $urandom_range(KEY_W - 1));
        end
    endfunction

    // Search for a held key (often the tail, to reach the last position)
    // or for an arbitrary one.
    task automatic probe_search();
        int n;
        int pos;
        n = shadow.held_keys();
        if (n > 0 && $urandom_range(99) < 70) begin
            pos = ($urandom_range(3) == 0) ? n - 1 : $urandom_range(n - 1);
            send_item(ACT_SEARCH, shadow.key_at(pos));
        end else begin
            send_item(ACT_SEARCH, draw_key());
        end
    endtask

    // Fill to full, with a few refused pushes past the top, then searches.
    task automatic fill_scene();
        int n;
        n = QDEPTH - shadow.held_keys() + $urandom_range(0, 3);
        repeat (n) send_item(ACT_PUSH, draw_key());
        repeat (4) probe_search();
    endtask

    // Empty the queue, a pop or two past empty, searches sprinkled in.
    task automatic drain_scene();
        int n;
        n = shadow.held_keys() + $urandom_range(0, 2);
        repeat (n) begin
            if ($urandom_range(4) == 0)
                probe_search();
            send_item(ACT_POP, draw_key());
        end
    endtask

    // Random mix of all actions; keys of pop and clear are ignored noise.
    task automatic mix_scene();
        int pick;
        repeat (24) begin
            pick = $urandom_range(99);
            if (pick < 36)
                send_item(ACT_PUSH, draw_key());
            else if (pick < 68)
                send_item(ACT_POP, draw_key());
            else if (pick < 96)
                probe_search();
            else
                send_item(ACT_CLEAR, draw_key());
        end
    endtask

    initial begin
        int phase;
        int pick;
        int unsigned target;
        shadow = new();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-queue corner cases, extreme keys, first-match
        // ordering, miss, clear and refused pop after clear.
        send_item(ACT_POP,    32'sh1234_5678);
        send_item(ACT_SEARCH, 32'sh0000_0005);
        send_item(ACT_CLEAR,  -32'sd1);
        send_item(ACT_PUSH,   32'sh8000_0000);
        send_item(ACT_PUSH,   32'sh7fff_ffff);
        send_item(ACT_PUSH,   32'sh0000_0000);
        send_item(ACT_PUSH,   -32'sd1);
        send_item(ACT_PUSH,   32'sh7fff_ffff);
        send_item(ACT_SEARCH, 32'sh8000_0000);
        send_item(ACT_SEARCH, 32'sh7fff_ffff);
        send_item(ACT_SEARCH, -32'sd1);
        send_item(ACT_SEARCH, 32'sh0000_3039);
        send_item(ACT_POP,    32'sh0000_0000);
        send_item(ACT_SEARCH, 32'sh8000_0000);
        send_item(ACT_CLEAR,  32'sh0000_0000);
        send_item(ACT_POP,    32'sh0000_0000);
        send_item(ACT_SEARCH, 32'sh7fff_ffff);
        send_item(ACT_PUSH,   32'sh5555_aaaa);
        send_item(ACT_SEARCH, 32'sh5555_aaaa);
        send_item(ACT_POP,    32'sh0000_0000);
        send_item(ACT_POP,    32'sh0000_0000);
        pause_until_drained();

        // Random: three idle mixes, scenes of fill / drain / mix.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 27;
                    dst_idle_pct = 63;
                end
                1: begin
                    src_idle_pct = 63;
                    dst_idle_pct = 27;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            // Back-pressure test: receiver holds off while a fill keeps
            // offering items, so the block backs up and drops s_ready.
            if (phase == 2) begin
                stall_asked <= stall_asked + 1;
                fill_scene();
            end
            while (items_sent < target) begin
                pick = $urandom_range(9);
                if (pick < 3)
                    fill_scene();
                else if (pick < 5)
                    drain_scene();
                else
                    mix_scene();
                if ($urandom_range(19) == 0)
                    pause_until_drained();
            end
            pause_until_drained();
        end

        // Let any stray result show up before closing.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d items (%0d results checked) over three idle mixes and a long stall.",
                 items_sent, shadow.checked);
        $display("Saw %0d refused pushes, %0d refused pops, %0d hits (%0d last slot), %0d clears.",
                 shadow.refused_pushes, shadow.refused_pops, shadow.search_hits,
                 shadow.last_slot_hits, shadow.clears);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
